// File: design/pwc_pkg.sv
package pwc_pkg;

  localparam int unsigned SideDefault   = 64;
  localparam int unsigned StatesDefault = 4;
  localparam int unsigned CountW        = 13;
  localparam int unsigned SiteW         = 12;
  localparam int unsigned StateW        = 4;

  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgSeed      = 1'b1;

  // walk sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StSeedRd,
    StSeedWr,
    StTopRd,
    StTopEval,
    StNbRd,
    StNbEval,
    StOut,
    StClear
  } pwc_state_e;

  // one xorshift (13,17,5) step
  function automatic logic [31:0] xs_step(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// File: design/potts_wolff_cluster_flip_unit.sv
// Channel   | Dir | Bits
// s_axis    | in  | tdata[11:0] start_site
// m_axis    | out | tdata[29:0] state_index, state_count, cluster_size; tlast last_of_run
// cfg       | in  | cfg_we_i, cfg_idx_i (0 threshold, 1 seed), cfg_wdata_i[31:0]
//
// Each flipped site takes four neighbor visits (stack read, evaluate, spin read, evaluate)
// plus a pop; around the walk an item also passes through seed handling, stack exit and
// idle, then STATES results, before the next accept. The spin RAM port (one read or write
// per cycle, registered read) sets this pace.
// Reset: a clearing pass writes state zero to all SIDE*SIDE spin entries, one per cycle,
// before the first item is taken.
// Stalls on m_axis hold the current result; no new item is taken until the run ends.
module potts_wolff_cluster_flip_unit
  import pwc_pkg::*;
#(
  parameter int unsigned SIDE   = SideDefault,
  parameter int unsigned STATES = StatesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] start_site
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] state_index, [16:4] state_count, [29:17] cluster_size
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned NSites = SIDE * SIDE;
  localparam int unsigned XW     = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned AW     = (NSites > 1) ? $clog2(NSites) : 1;
  localparam int unsigned SW     = $clog2(STATES);
  localparam int unsigned PW     = AW + 1;
  localparam int unsigned EW     = AW + XW + 3;

  // reciprocal constants: floor(v / d) == (v * Mul) >> Shift for every 12-bit v
  localparam int unsigned NShift = SiteW + AW;
  localparam int unsigned NMul   =
    32'(((64'd1 << NShift) + 64'(NSites) - 64'd1) / 64'(NSites));
  localparam int unsigned SShift = SiteW + XW;
  localparam int unsigned SMul   =
    32'(((64'd1 << SShift) + 64'(SIDE) - 64'd1) / 64'(SIDE));

  pwc_state_e st_q, st_d;

  logic [15:0]     thr_q;
  logic [31:0]     rng_q;
  logic [SW-1:0]   old_q, new_q;
  logic [CountW-1:0] flips_q;
  logic [CountW-1:0] cnt_q [STATES];
  logic [PW-1:0]   sp_q;
  logic [AW-1:0]   site_q, nb_q;
  logic [XW-1:0]   sx_q, nbx_q;
  logic [SW-1:0]   oidx_q;
  logic [AW-1:0]   clr_q;

  // spin store, cleared to state zero by a pass after reset
  logic [StateW-1:0] spin_mem [NSites];
  logic [StateW-1:0] spin_rd_q;
  logic [SW-1:0]     spin_val;

  // walk stack: site, its column and next direction
  logic [EW-1:0]   stk_mem [NSites];
  logic [EW-1:0]   stk_rd_q;

  logic [SiteW-1:0] seed_in;
  logic [31:0]      seed_quo;
  logic [AW-1:0]    seed_site;
  logic [31:0]      sx_quo;
  logic [XW-1:0]    seed_x;
  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    top_site;
  logic [XW-1:0]    top_x;
  logic [2:0]       top_dir;
  logic [AW-1:0]    nb_site;
  logic [XW-1:0]    nb_x;
  logic [31:0]      rng_nx;
  logic             join_w;

  // reduce the seed modulo the lattice size, then split off its column
  // (site_q always comes from a 12-bit seed, so the same reciprocal holds)
  assign seed_in   = s_axis_tdata[SiteW-1:0];
  assign seed_quo  = (32'(seed_in) * NMul) >> NShift;
  assign seed_site = AW'(32'(seed_in) - seed_quo * NSites);
  assign sx_quo    = (32'(site_q) * SMul) >> SShift;
  assign seed_x    = XW'(32'(site_q) - sx_quo * SIDE);

  assign top_addr  = AW'(sp_q - PW'(1));
  assign top_site  = stk_rd_q[EW-1:XW+3];
  assign top_x     = stk_rd_q[XW+2:3];
  assign top_dir   = stk_rd_q[2:0];
  assign spin_val  = spin_rd_q[SW-1:0];
  assign rng_nx    = xs_step(rng_q);
  assign join_w    = (rng_nx[31:16] < thr_q);

  // neighbor of the stacked site in direction top_dir, wrapping at the edges
  always_comb begin
    nb_site = top_site;
    nb_x    = top_x;
    case (top_dir[1:0])
      2'd0: begin
        if (32'(top_x) == SIDE - 1) begin
          nb_x    = '0;
          nb_site = AW'(32'(top_site) - (SIDE - 1));
        end else begin
          nb_x    = top_x + XW'(1);
          nb_site = top_site + AW'(1);
        end
      end
      2'd1: begin
        if (top_x == '0) begin
          nb_x    = XW'(SIDE - 1);
          nb_site = AW'(32'(top_site) + (SIDE - 1));
        end else begin
          nb_x    = top_x - XW'(1);
          nb_site = top_site - AW'(1);
        end
      end
      2'd2: begin
        nb_site = (32'(top_site) >= NSites - SIDE) ? AW'(32'(top_site) - (NSites - SIDE))
                                                   : AW'(32'(top_site) + SIDE);
      end
      default: begin
        nb_site = (32'(top_site) < SIDE) ? AW'(32'(top_site) + (NSites - SIDE))
                                         : AW'(32'(top_site) - SIDE);
      end
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StClear:   if (32'(clr_q) == NSites - 1) st_d = StIdle;
      StIdle:    if (s_axis_tvalid) st_d = StSeedRd;
      StSeedRd:  st_d = StSeedWr;
      StSeedWr:  st_d = StTopRd;
      StTopRd:   st_d = (sp_q == '0) ? StOut : StTopEval;
      StTopEval: st_d = (top_dir[2]) ? StTopRd : StNbRd;
      StNbRd:    st_d = StNbEval;
      StNbEval:  st_d = StTopRd;
      StOut:     if (m_axis_tready && 32'(oidx_q) == STATES - 1) st_d = StIdle;
      default:   st_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (st_q == StIdle);
    m_axis_tvalid = (st_q == StOut);
    m_axis_tlast  = (32'(oidx_q) == STATES - 1);
    m_axis_tdata  = {2'b00, flips_q, cnt_q[oidx_q], StateW'(oidx_q)};
  end

  // spin memory: read address depends on phase
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle:  spin_rd_q <= spin_mem[seed_site];
      StNbRd:  spin_rd_q <= spin_mem[nb_q];
      default: ;
    endcase
    if (st_q == StClear) spin_mem[clr_q] <= '0;
    if (st_q == StSeedWr) spin_mem[site_q] <= StateW'(new_q);
    if (st_q == StNbEval && spin_val == old_q && join_w) spin_mem[nb_q] <= StateW'(new_q);
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    stk_rd_q <= stk_mem[top_addr];
    if (st_q == StSeedWr) stk_mem['0] <= {site_q, sx_q, 3'd0};
    else if (st_q == StTopEval && !top_dir[2])
      stk_mem[top_addr] <= {top_site, top_x, top_dir + 3'd1};
    else if (st_q == StNbEval && spin_val == old_q && join_w)
      stk_mem[sp_q[AW-1:0]] <= {nb_q, nbx_q, 3'd0};
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StClear;
      thr_q         <= '0;
      rng_q         <= 32'd1;
      old_q         <= '0;
      new_q         <= '0;
      flips_q       <= '0;
      sp_q          <= '0;
      oidx_q        <= '0;
      clr_q         <= '0;
      site_q        <= '0;
      sx_q          <= '0;
      nb_q          <= '0;
      nbx_q         <= '0;
      for (int s = 0; s < STATES; s++) cnt_q[s] <= (s == 0) ? CountW'(NSites) : '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgThreshold) thr_q <= cfg_wdata_i[15:0];
        else rng_q <= (cfg_wdata_i == '0) ? 32'd1 : cfg_wdata_i;
      end
      case (st_q)
        StClear: clr_q <= clr_q + AW'(1);
        StIdle: begin
          if (s_axis_tvalid) site_q <= seed_site;
        end
        StSeedRd: begin
          old_q <= spin_val;
          new_q <= (32'(spin_val) == STATES - 1) ? '0 : spin_val + SW'(1);
          sx_q  <= seed_x;
        end
        StSeedWr: begin
          cnt_q[old_q] <= cnt_q[old_q] - CountW'(1);
          cnt_q[new_q] <= cnt_q[new_q] + CountW'(1);
          flips_q <= CountW'(1);
          sp_q    <= PW'(1);
        end
        StTopEval: begin
          if (top_dir[2]) sp_q <= sp_q - PW'(1);
          else begin
            nb_q  <= nb_site;
            nbx_q <= nb_x;
          end
        end
        StNbEval: begin
          if (spin_val == old_q) begin
            rng_q <= rng_nx;
            if (join_w) begin
              cnt_q[old_q] <= cnt_q[old_q] - CountW'(1);
              cnt_q[new_q] <= cnt_q[new_q] + CountW'(1);
              flips_q <= flips_q + CountW'(1);
              sp_q    <= sp_q + PW'(1);
            end
          end
        end
        StOut: begin
          if (m_axis_tready) oidx_q <= (32'(oidx_q) == STATES - 1) ? '0 : oidx_q + SW'(1);
        end
        default: ;
      endcase
    end
  end

  // stack never exceeds lattice size
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= NSites) else $error("stack overflow");
  // no input taken while results pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("overlap");
  // cluster holds at least the seed when reporting
  a_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> flips_q != '0) else $error("empty cluster");
  // walk ends with empty stack
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StTopRd && st_d == StOut) |-> sp_q == '0) else $error("early end");

endmodule

// File: dv/tb_top.sv
module tb_top;
  import pwc_pkg::*;

  localparam int unsigned Side   = SideDefault;
  localparam int unsigned States = StatesDefault;
  localparam int unsigned Sites  = Side * Side;

  typedef enum int {DirRight, DirLeft, DirUp, DirDown, DirDone} walk_dir_e;

  typedef struct packed {
    logic [StateW-1:0] state_idx;
    logic [CountW-1:0] state_cnt;
    logic [CountW-1:0] size;
    logic              last;
  } tally_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [11:0] start_site
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [3:0] state_index, [16:4] state_count, [29:17] cluster_size
  logic        m_axis_tlast;   // last_of_run
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  // lattice mirror
  logic [StateW-1:0] lattice [Sites];
  int unsigned       state_pop [States];
  int unsigned       stack_site [Sites];
  walk_dir_e         stack_dir [Sites];
  logic [15:0]       bond_thresh;
  logic [31:0]       xs_word;

  tally_t      tally_q[$];
  int unsigned err_cnt;
  int unsigned tally_seen;
  int unsigned items_sent;
  int unsigned max_cluster;
  bit          rx_no_stall;

  potts_wolff_cluster_flip_unit #(.SIDE(Side), .STATES(States)) u_dut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #(1_500_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] next_draw();
    logic [31:0] x;
    x = xs_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    xs_word = x;
    return x[31:16];
  endfunction

  function automatic int unsigned step_site(int unsigned site, walk_dir_e dir);
    int unsigned x;
    int unsigned y;
    x = site % Side;
    y = site / Side;
    case (dir)
      DirRight: x = (x + 1) % Side;
      DirLeft:  x = (x + Side - 1) % Side;
      DirUp:    y = (y + 1) % Side;
      default:  y = (y + Side - 1) % Side;
    endcase
    return y * Side + x;
  endfunction

  // grow one cluster on the mirror and queue the per-state tallies
  function automatic void grow_cluster(logic [SiteW-1:0] start);
    int unsigned seed;
    logic [StateW-1:0] old_st;
    logic [StateW-1:0] new_st;
    int unsigned depth;
    int unsigned flips;
    int unsigned site;
    int unsigned nb;
    walk_dir_e   dir;
    tally_t      t;
    seed   = 32'(start) % Sites;
    old_st = lattice[seed];
    new_st = StateW'((32'(old_st) + 1) % States);
    lattice[seed] = new_st;
    state_pop[old_st]--;
    state_pop[new_st]++;
    flips = 1;
    stack_site[0] = seed;
    stack_dir[0]  = DirRight;
    depth = 1;
    while (depth > 0) begin
      site = stack_site[depth-1];
      dir  = stack_dir[depth-1];
      if (dir == DirDone) begin
        depth--;
      end else begin
        stack_dir[depth-1] = walk_dir_e'(int'(dir) + 1);
        nb = step_site(site, dir);
        if (lattice[nb] == old_st && next_draw() < bond_thresh) begin
          lattice[nb] = new_st;
          state_pop[old_st]--;
          state_pop[new_st]++;
          flips++;
          stack_site[depth] = nb;
          stack_dir[depth]  = DirRight;
          depth++;
        end
      end
    end
    if (flips > max_cluster) max_cluster = flips;
    for (int s = 0; s < States; s++) begin
      t.state_idx = StateW'(s);
      t.state_cnt = CountW'(state_pop[s]);
      t.size      = CountW'(flips);
      t.last      = (s == States - 1);
      tally_q.push_back(t);
    end
  endfunction

  // receiver side: random backpressure
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0 && !rx_no_stall) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest tally
  always @(posedge clk_i) begin
    tally_t got;
    tally_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.state_idx = m_axis_tdata[3:0];
      got.state_cnt = m_axis_tdata[16:4];
      got.size      = m_axis_tdata[29:17];
      got.last      = m_axis_tlast;
      tally_seen++;
      if (tally_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        err_cnt++;
      end else begin
        want = tally_q.pop_front();
        if (got.state_idx !== want.state_idx) begin
          $display("%0t: state_index exp %0d got %0d", $time, want.state_idx, got.state_idx);
          err_cnt++;
        end
        if (got.state_cnt !== want.state_cnt) begin
          $display("%0t: state_count exp %0d got %0d", $time, want.state_cnt, got.state_cnt);
          err_cnt++;
        end
        if (got.size !== want.size) begin
          $display("%0t: cluster_size exp %0d got %0d", $time, want.size, got.size);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run exp %0d got %0d", $time, want.last, got.last);
          err_cnt++;
        end
      end
    end
  end

  // send one seed site, predict on acceptance, then idle for the given gap
  task automatic send_site(logic [SiteW-1:0] site, int unsigned gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, site};
    do @(posedge clk_i); while (!s_axis_tready);
    grow_cluster(site);
    items_sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for all tallies, then stay quiet before returning
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CfgThreshold) begin
      bond_thresh = data[15:0];
    end else begin
      xs_word = (data == 0) ? 32'd1 : data;
    end
    @(posedge clk_i);
  endtask

  // threshold zero: every cluster is the seed alone, lattice corners and edges
  task automatic test_single_sites();
    logic [SiteW-1:0] pts [8] = '{12'd0, 12'd63, 12'd64, 12'd4032, 12'd4095,
                                  12'd2047, 12'd2048, 12'd0};
    write_reg(CfgThreshold, 32'd0);
    write_reg(CfgSeed, 32'hFFFF_FFFF);
    foreach (pts[i]) send_site(pts[i], pick_gap());
    drain();
  endtask

  // full bonds: the whole same-state region flips, twice in a row
  task automatic test_full_bonds();
    write_reg(CfgThreshold, 32'h0000_FFFF);
    write_reg(CfgSeed, 32'd1);
    send_site(12'd1000, 0);
    send_site(12'd4095, pick_gap());
    drain();
  endtask

  // zero seed loads one; mid threshold
  task automatic test_zero_seed();
    write_reg(CfgSeed, 32'd0);
    write_reg(CfgThreshold, 32'h0000_8000);
    for (int i = 0; i < 6; i++) send_site(SiteW'($urandom_range(0, Sites - 1)), pick_gap());
    drain();
  endtask

  // random phases with fresh thresholds and seeds
  task automatic test_random_clusters(int unsigned total);
    int unsigned n;
    int unsigned r;
    logic [31:0] th;
    while (items_sent < total) begin
      r = $urandom_range(0, 99);
      if (r < 5)       th = 32'h0000_FFFF;
      else if (r < 12) th = 32'd0;
      else             th = $urandom_range(0, 16'h7000);
      write_reg(CfgThreshold, th);
      if ($urandom_range(0, 2) == 0) write_reg(CfgSeed, $urandom());
      rx_no_stall = ($urandom_range(0, 4) == 0);
      n = (th == 32'h0000_FFFF) ? 1 : $urandom_range(4, 20);
      for (int i = 0; i < n; i++) begin
        send_site(SiteW'($urandom_range(0, Sites - 1)), pick_gap());
      end
      drain();
    end
    rx_no_stall = 1'b0;
  endtask

  initial begin
    foreach (lattice[i]) lattice[i] = '0;
    foreach (state_pop[i]) state_pop[i] = 0;
    state_pop[0] = Sites;
    bond_thresh   = '0;
    xs_word       = 32'd1;
    err_cnt       = 0;
    tally_seen    = 0;
    items_sent    = 0;
    max_cluster   = 0;
    rx_no_stall   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgThreshold;
    cfg_wdata_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sites();
    test_full_bonds();
    test_zero_seed();
    test_random_clusters(210);

    $display("Covered %0d seed sites and %0d state tallies, largest cluster %0d sites,",
             items_sent, tally_seen, max_cluster);
    $display("thresholds from zero to full bonds and seeds including zero and all ones.");
    if (err_cnt == 0 && tally_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
